### design/latency_weighted_route_selector_core_assert.svh
// Assertion macros shared by the route selector checker.
// No dependencies; included by the checker file.
`ifndef LATENCY_WEIGHTED_ROUTE_SELECTOR_CORE_ASSERT_SVH
`define LATENCY_WEIGHTED_ROUTE_SELECTOR_CORE_ASSERT_SVH

// Immediate implication checked on every clock edge outside reset.
`define LWRS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked on every clock edge outside reset.
`define LWRS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/lwrs_pkg.sv
// Shared types and constants of the latency weighted route selector.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
package lwrs_pkg;
    localparam int MAX_ENTRIES_DEF = 16;
    localparam int POOL_LIMIT      = 16;
    localparam int CAND_IDX_W      = 8;

    localparam logic [1:0] KIND_TICK    = 2'd0;
    localparam logic [1:0] KIND_SELECT  = 2'd1;
    localparam logic [1:0] KIND_SUCCESS = 2'd2;
    localparam logic [1:0] KIND_FAILURE = 2'd3;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_EMPTY     = 2'd1;
    localparam logic [1:0] STATUS_BAD_INDEX = 2'd2;

    localparam logic [1:0] REG_ENTRY_COUNT   = 2'd0;
    localparam logic [1:0] REG_DEFAULT_LAT   = 2'd1;
    localparam logic [1:0] REG_MAX_SHIFT     = 2'd2;

    // Reciprocal of five in 2^-29 units, exact for dividends below 2^27.
    localparam logic [26:0] RECIP5     = 27'd107374183;
    localparam int          RECIP5_SHR = 29;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  entry_index;
        logic [15:0] latency_ms;
    } t_item;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] chosen_index;
        logic       all_quarantined;
    } t_result;

    // Candidate record that travels down the row of cells during a select.
    typedef struct packed {
        logic                  valid;
        logic                  found;
        logic [CAND_IDX_W-1:0] best_idx;
        logic [33:0]           lead_score;
        logic [CAND_IDX_W-1:0] fb_idx;
        logic [39:0]           fb_dl;
    } t_cand;

    // Update broadcast to the cells at the end of a report.
    typedef struct packed {
        logic        en;
        logic [3:0]  idx;
        logic [23:0] avg;
        logic [7:0]  fc;
        logic [39:0] dl;
    } t_wr;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_READ,
        ST_CALC,
        ST_WRITE
    } t_state;
endpackage

### design/lwrs_cell.sv
// One route cell: holds a route's state, scores it, and refines the
// candidate record passed along the row. Depends on lwrs_pkg.
`timescale 1ns / 1ps
module lwrs_cell #(
    parameter int IDX = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  lwrs_pkg::t_cand i_cand,
    output lwrs_pkg::t_cand o_cand,
    input  logic [39:0]    i_now,
    input  logic [15:0]    i_dflt,
    input  logic [4:0]     i_pool,
    input  lwrs_pkg::t_wr  i_wr,
    output logic [23:0]    o_avg,
    output logic [7:0]     o_fc
);
    import lwrs_pkg::*;

    localparam logic [8:0] IDX9 = 9'(IDX);

    logic [23:0] r_avg;
    logic [7:0]  r_fc;
    logic [39:0] r_dl;
    t_cand       r_cand;
    t_cand       n_cand;
    logic [23:0] lat;
    logic [9:0]  weight;
    logic [33:0] score;
    logic        quar;
    logic        active;

    // The score follows the stored state directly, so a write or a tick just
    // before a select is already seen by it.
    assign lat    = (r_avg != 24'd0) ? r_avg : {i_dflt, 8'd0};
    assign weight = 10'd4 + 10'd3 * {2'd0, r_fc};
    assign score  = {10'd0, lat} * {24'd0, weight};
    assign quar   = r_dl > i_now;
    assign active = IDX9 < {4'd0, i_pool};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg  <= '0;
            r_fc   <= '0;
            r_dl   <= '0;
            r_cand <= '0;
        end else begin
            r_cand <= n_cand;
            if (i_wr.en && (IDX9 == {5'd0, i_wr.idx})) begin
                r_avg <= i_wr.avg;
                r_fc  <= i_wr.fc;
                r_dl  <= i_wr.dl;
            end
        end
    end

    always_comb begin
        n_cand = i_cand;
        if (i_cand.valid && active) begin
            if (!quar && (!i_cand.found || score < i_cand.lead_score)) begin
                n_cand.found      = 1'b1;
                n_cand.best_idx   = IDX9[CAND_IDX_W-1:0];
                n_cand.lead_score = score;
            end
            if (r_dl < i_cand.fb_dl) begin
                n_cand.fb_idx = IDX9[CAND_IDX_W-1:0];
                n_cand.fb_dl  = r_dl;
            end
        end
    end

    assign o_cand = r_cand;
    assign o_avg  = r_avg;
    assign o_fc   = r_fc;
endmodule

### design/latency_weighted_route_selector_core.sv
// Latency weighted route selector: a tick only advances the clock, a report passes through
// the read, calc and write states, and a select lasts until the candidate record, walking
// the row of cells one cell per clock, leaves the last cell. busy is high while a report or
// a select is in flight, so a new one waits until the last is through; ticks go back to
// back. Results are strobed for one cycle and cannot be stalled. Synchronous active-low
// reset clears all route state and the clock and resets the config registers.
`timescale 1ns / 1ps
module latency_weighted_route_selector_core #(
    parameter int MAX_ENTRIES = lwrs_pkg::MAX_ENTRIES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  lwrs_pkg::t_item   i_item,
    output logic              o_done,
    output lwrs_pkg::t_result o_result,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [15:0]       i_cfg_wdata
);
    import lwrs_pkg::*;

    // The pool never exceeds sixteen routes nor the number of cells.
    localparam int POOL_CAP = (MAX_ENTRIES < POOL_LIMIT) ? MAX_ENTRIES : POOL_LIMIT;

    // Configuration registers.
    logic [4:0]  r_entry_count;
    logic [15:0] r_dflt;
    logic [3:0]  r_max_shift;
    logic [4:0]  pool;

    // Transaction state.
    t_state      r_state, n_state;
    logic [39:0] r_now;
    t_item       r_item;
    logic [23:0] r_old;
    logic [7:0]  r_fc;
    logic [53:0] r_prod;
    logic [7:0]  r_newfc;
    logic [39:0] r_dl;
    logic        r_done, n_done;
    t_result     r_res, n_res;

    logic        accept;
    t_cand       chain_in;
    t_cand       chain [MAX_ENTRIES];
    logic [23:0] c_avg [MAX_ENTRIES];
    logic [7:0]  c_fc  [MAX_ENTRIES];
    t_wr         wr;
    logic [23:0] rd_avg;
    logic [7:0]  rd_fc;
    logic [26:0] div_num;
    logic [7:0]  fc_inc;
    logic [3:0]  shift;
    t_cand       last;

    assign pool   = (r_entry_count > 5'(POOL_CAP)) ? 5'(POOL_CAP) : r_entry_count;
    assign accept = start && !busy;
    assign busy   = (r_state != ST_IDLE);
    assign last   = chain[MAX_ENTRIES-1];

    // A select launches a fresh candidate record into the first cell. The
    // fallback deadline starts at its largest value, so the first route
    // always becomes the earliest-deadline fallback unless one beats it.
    always_comb begin
        chain_in            = '0;
        chain_in.valid      = accept && (i_item.kind == KIND_SELECT) && (pool != 5'd0);
        chain_in.lead_score = '1;
        chain_in.fb_dl      = '1;
    end

    // Row of cells; each hands its candidate record to the next every cycle.
    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        lwrs_cell #(.IDX(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cand  ((g == 0) ? chain_in : chain[(g == 0) ? 0 : g-1]),
            .o_cand  (chain[g]),
            .i_now   (r_now),
            .i_dflt  (r_dflt),
            .i_pool  (pool),
            .i_wr    (wr),
            .o_avg   (c_avg[g]),
            .o_fc    (c_fc[g])
        );
    end

    // Read port for reports: select the addressed route's state.
    always_comb begin
        rd_avg = '0;
        rd_fc  = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if ((i < POOL_LIMIT) && (r_item.entry_index == 4'(i))) begin
                rd_avg = rd_avg | c_avg[i];
                rd_fc  = rd_fc | c_fc[i];
            end
        end
    end

    // Success: (sample + 4 * old + 2) / 5 through a reciprocal multiply.
    assign div_num = {3'd0, r_item.latency_ms, 8'd0} + {1'b0, r_old, 2'd0} + 27'd2;
    // Failure: saturating count and backoff shift capped by the register.
    assign fc_inc  = (r_fc == 8'hFF) ? r_fc : r_fc + 8'd1;
    assign shift   = (fc_inc < {4'd0, r_max_shift}) ? fc_inc[3:0] : r_max_shift;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_now         <= '0;
            r_entry_count <= 5'd0;
            r_dflt        <= 16'd500;
            r_max_shift   <= 4'd6;
            r_done        <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            if (accept && (i_item.kind == KIND_TICK)) begin
                r_now <= r_now + 40'd1;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_ENTRY_COUNT: r_entry_count <= i_cfg_wdata[4:0];
                    REG_DEFAULT_LAT: r_dflt        <= i_cfg_wdata;
                    REG_MAX_SHIFT:   r_max_shift   <= i_cfg_wdata[3:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Datapath registers need no reset.
    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (accept) begin
            r_item <= i_item;
        end
        if (r_state == ST_READ) begin
            r_old <= rd_avg;
            r_fc  <= rd_fc;
        end
        if (r_state == ST_CALC) begin
            r_prod  <= {27'd0, div_num} * {27'd0, RECIP5};
            r_newfc <= fc_inc;
            r_dl    <= r_now + (40'd1000 << shift);
        end
    end

    // Next state, result and the write broadcast.
    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        n_res   = '0;
        wr      = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (i_item.kind)
                        KIND_TICK: begin
                            n_done = 1'b1;
                        end
                        KIND_SELECT: begin
                            if (pool == 5'd0) begin
                                n_done       = 1'b1;
                                n_res.status = STATUS_EMPTY;
                            end else begin
                                n_state = ST_SCAN;
                            end
                        end
                        default: begin
                            if ({1'b0, i_item.entry_index} >= pool) begin
                                n_done       = 1'b1;
                                n_res.status = STATUS_BAD_INDEX;
                            end else begin
                                n_state = ST_READ;
                            end
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (last.valid) begin
                    n_state                = ST_IDLE;
                    n_done                 = 1'b1;
                    n_res.all_quarantined  = !last.found;
                    n_res.chosen_index     = last.found ? last.best_idx[3:0] : last.fb_idx[3:0];
                end
            end
            ST_READ: begin
                n_state = ST_CALC;
            end
            ST_CALC: begin
                n_state = ST_WRITE;
            end
            ST_WRITE: begin
                n_state = ST_IDLE;
                n_done  = 1'b1;
                wr.en   = 1'b1;
                wr.idx  = r_item.entry_index;
                if (r_item.kind == KIND_SUCCESS) begin
                    wr.avg = (r_old == 24'd0) ? {r_item.latency_ms, 8'd0}
                                              : r_prod[RECIP5_SHR+23:RECIP5_SHR];
                    wr.fc  = 8'd0;
                    wr.dl  = 40'd0;
                end else begin
                    wr.avg = r_old;
                    wr.fc  = r_newfc;
                    wr.dl  = r_dl;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_done   = r_done;
    assign o_result = r_res;
endmodule

### design/lwrs_checker.sv
// Port-level checker for the route selector and its bind to the top level.
// Depends on lwrs_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "latency_weighted_route_selector_core_assert.svh"
module lwrs_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_done,
    input lwrs_pkg::t_result o_result
);
    import lwrs_pkg::*;

    `LWRS_ASSERT_IMP(a_done_idle, o_done, !busy, "result shown while still busy")
    `LWRS_ASSERT_IMP(a_err_zero, o_done && (o_result.status != STATUS_OK), (o_result.chosen_index == 4'd0) && !o_result.all_quarantined, "error result carries a choice")
    `LWRS_ASSERT_IMP(a_quar_strobe, o_result.all_quarantined, o_done, "fallback flag without a result")
    `LWRS_ASSERT_IMP(a_done_cause, o_done, $past(busy) || $past(start), "result without a transaction")
endmodule

bind latency_weighted_route_selector_core lwrs_checker u_lwrs_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_done   (o_done),
    .o_result (o_result)
);
